>>> rtl/sawbc_pkg.sv
// Shared types, constants and address helpers for the set-associative cache.
// No dependencies.
`default_nettype none
package sawbc_pkg;
    localparam int WAYS      = 8;
    localparam int SETS      = 256;
    localparam int WPL       = 8;
    localparam int SET_W     = 8;
    localparam int WAY_W     = 3;
    localparam int WORD_W    = 3;
    localparam int TAG_W     = 21;
    localparam int AGE_W     = 16;
    localparam int DADDR_W   = SET_W + WAY_W + WORD_W;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_FILL  = 2'd2;

    localparam logic [1:0] KIND_DONE = 2'd0;
    localparam logic [1:0] KIND_WB   = 2'd1;
    localparam logic [1:0] KIND_REQ  = 2'd2;

    localparam logic REG_DATA_MODE   = 1'b0;
    localparam logic REG_ACTIVE_WAYS = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             dirty;
        logic [TAG_W-1:0] tag;
        logic [AGE_W-1:0] age;
    } way_t;

    typedef way_t [WAYS-1:0] row_t;

    typedef struct packed {
        logic             rd_en;
        logic [SET_W-1:0] rd_set;
        logic             wr_en;
        logic [SET_W-1:0] wr_set;
    } tag_req_t;

    typedef struct packed {
        logic               en;
        logic               we;
        logic [DADDR_W-1:0] addr;
        logic [31:0]        wdata;
    } dat_req_t;

    function automatic logic [SET_W-1:0] set_of(input logic [31:0] a, input logic dm);
        return dm ? a[12:5] : {2'b00, a[10:5]};
    endfunction

    function automatic logic [TAG_W-1:0] tag_of(input logic [31:0] a, input logic dm);
        return dm ? {2'b00, a[31:13]} : a[31:11];
    endfunction
endpackage
`default_nettype wire

>>> rtl/sawbc_tag_store.sv
// Tag/state row memory, one row of all ways per set, with per-row valid flops.
// Depends on sawbc_pkg.
`default_nettype none
module sawbc_tag_store (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire sawbc_pkg::tag_req_t req,
    input  wire sawbc_pkg::row_t   wr_row,
    output sawbc_pkg::row_t        rd_row
);
    sawbc_pkg::row_t mem [sawbc_pkg::SETS];
    logic [sawbc_pkg::SETS-1:0] row_ok_reg;
    sawbc_pkg::row_t rd_reg;
    logic rd_ok_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_set] <= wr_row;
        end
        if (req.rd_en) begin
            rd_reg <= mem[req.rd_set];
        end
    end

    // an unwritten row reads as all zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_ok_reg <= '0;
            rd_ok_reg  <= 1'b0;
        end else begin
            if (req.wr_en) row_ok_reg[req.wr_set] <= 1'b1;
            if (req.rd_en) rd_ok_reg <= row_ok_reg[req.rd_set];
        end
    end

    assign rd_row = rd_ok_reg ? rd_reg : '0;
endmodule
`default_nettype wire

>>> rtl/sawbc_data_store.sv
// Line word memory, single port, registered read held between reads.
// Depends on sawbc_pkg.
`default_nettype none
module sawbc_data_store (
    input  wire logic                aclk,
    input  wire sawbc_pkg::dat_req_t req,
    output logic [31:0]              rdata
);
    logic [31:0] mem [2**sawbc_pkg::DADDR_W];
    logic [31:0] rd_reg;

    always_ff @(posedge aclk) begin
        if (req.en) begin
            if (req.we) mem[req.addr] <= req.wdata;
            else        rd_reg <= mem[req.addr];
        end
    end

    assign rdata = rd_reg;
endmodule
`default_nettype wire

>>> rtl/set_assoc_writeback_cache_core.sv
// Top level of the set-associative write-back cache: control sequencer.
// Depends on sawbc_pkg, sawbc_tag_store, sawbc_data_store.
//
// Input channel s_*: one item is a read, a write or a memory fill beat
// (s_tuser = mode). Result channel m_*: completions, writeback beats and
// fill requests (m_tuser = kind, hit); m_tlast marks the last result of an item.
// An access looks up its set in the tag row memory, updates the LRU ages and
// writes the row back. A hit accesses its word in ST_LOOKUP and completes
// from ST_RESP. A miss with a dirty victim emits eight writeback beats (one
// per cycle unless the output stalls, paced by the single data RAM port),
// then the fill request; a clean miss emits only the request. Fill beats are
// taken one per cycle; the eighth updates the row in ST_FILL and completes
// the access from ST_RESP. Accesses arriving while a miss is pending are
// dropped, as are stray fills. One item is in work at a time; the next item
// is accepted as soon as the sequencer is idle, even while the last result
// waits in the output register. Reset: all lines invalid (per-set valid
// flops, no clearing pass), no miss pending, data_mode 1, active_ways 8. A
// stalled receiver holds the result register and the sequencer waits on it.
`default_nettype none
module set_assoc_writeback_cache_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // addr, write_data, fill_data
    input  wire logic [1:0]  s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // read_data, mem_addr, mem_data
    output logic [2:0]       m_tuser,   // kind, hit
    output logic             m_tlast,
    input  wire logic        cfg_wen,
    input  wire logic        cfg_index,
    input  wire logic [3:0]  cfg_wdata
);
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LOOKUP = 6'b000010,
        ST_WB     = 6'b000100,
        ST_REQ    = 6'b001000,
        ST_FILL   = 6'b010000,
        ST_RESP   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic       data_mode_reg;
    logic [3:0] active_ways_reg;

    logic        pend_valid_reg, pend_valid_next;
    logic        pend_write_reg, pend_write_next;
    logic [31:0] pend_addr_reg, pend_addr_next;
    logic [31:0] pend_data_reg, pend_data_next;
    logic [2:0]  victim_reg, victim_next;
    logic [2:0]  fill_cnt_reg, fill_cnt_next;

    logic [31:0] cur_addr_reg, cur_addr_next;
    logic [31:0] cur_data_reg, cur_data_next;
    logic        cur_write_reg, cur_write_next;
    logic [7:0]  cur_set_reg, cur_set_next;
    logic [2:0]  wb_cnt_reg, wb_cnt_next;
    logic [18:0] wb_tag_reg, wb_tag_next;
    logic        resp_hit_reg, resp_hit_next;
    logic        resp_read_reg, resp_read_next;

    logic        mv_reg, mv_next;
    logic [95:0] md_reg, md_next;
    logic [2:0]  mu_reg, mu_next;
    logic        ml_reg, ml_next;

    sawbc_pkg::tag_req_t tag_req;
    sawbc_pkg::dat_req_t dat_req;
    sawbc_pkg::row_t     rd_row, wr_row, aged_row;
    logic [31:0]         dat_rdata;

    logic        accept, out_free;
    logic [3:0]  nways;
    logic [31:0] in_addr, in_wd, in_fd;
    logic [7:0]  pset;

    // lookup results
    logic       hit;
    logic [2:0] hit_way, vict;
    logic       found_empty;
    logic [15:0] big;
    logic [20:0] ctag;

    sawbc_tag_store u_tag (
        .aclk(aclk), .aresetn(aresetn), .req(tag_req), .wr_row(wr_row), .rd_row(rd_row)
    );
    sawbc_data_store u_dat (.aclk(aclk), .req(dat_req), .rdata(dat_rdata));

    assign in_addr  = s_tdata[31:0];
    assign in_wd    = s_tdata[63:32];
    assign in_fd    = s_tdata[95:64];
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !mv_reg || m_tready;
    assign pset     = sawbc_pkg::set_of(pend_addr_reg, data_mode_reg);

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tuser  = mu_reg;
    assign m_tlast  = ml_reg;

    always_comb begin
        if (active_ways_reg == 4'd0)      nways = 4'd1;
        else if (active_ways_reg > 4'd8)  nways = 4'd8;
        else                              nways = active_ways_reg;
    end

    // age update and victim choice over the row read at lookup
    always_comb begin
        logic stop;
        ctag        = sawbc_pkg::tag_of(cur_addr_reg, data_mode_reg);
        aged_row    = rd_row;
        hit         = 1'b0;
        hit_way     = 3'd0;
        for (int i = 0; i < sawbc_pkg::WAYS; i++) begin
            if (4'(i) < nways && rd_row[i].valid) begin
                if (rd_row[i].tag == ctag) begin
                    aged_row[i].age = '0;
                    if (!hit) hit_way = 3'(i);
                    hit = 1'b1;
                end else if (rd_row[i].age != 16'hFFFF) begin
                    aged_row[i].age = rd_row[i].age + 16'd1;
                end
            end
        end
        vict        = 3'd0;
        found_empty = 1'b0;
        stop        = 1'b0;
        big         = aged_row[0].age;
        for (int i = 0; i < sawbc_pkg::WAYS; i++) begin
            if (4'(i) < nways && !stop) begin
                if (!aged_row[i].valid) begin
                    vict = 3'(i); found_empty = 1'b1; stop = 1'b1;
                end else if (aged_row[i].age > big) begin
                    big = aged_row[i].age; vict = 3'(i);
                end
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        pend_valid_next = pend_valid_reg;
        pend_write_next = pend_write_reg;
        pend_addr_next  = pend_addr_reg;
        pend_data_next  = pend_data_reg;
        victim_next     = victim_reg;
        fill_cnt_next   = fill_cnt_reg;
        cur_addr_next   = cur_addr_reg;
        cur_data_next   = cur_data_reg;
        cur_write_next  = cur_write_reg;
        cur_set_next    = cur_set_reg;
        wb_cnt_next     = wb_cnt_reg;
        wb_tag_next     = wb_tag_reg;
        resp_hit_next   = resp_hit_reg;
        resp_read_next  = resp_read_reg;
        mv_next         = mv_reg && !m_tready;
        md_next         = md_reg;
        mu_next         = mu_reg;
        ml_next         = ml_reg;
        tag_req         = '0;
        dat_req         = '0;
        wr_row          = aged_row;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if ((s_tuser == sawbc_pkg::MODE_READ || s_tuser == sawbc_pkg::MODE_WRITE)
                        && !pend_valid_reg) begin
                        cur_addr_next  = in_addr;
                        cur_data_next  = in_wd;
                        cur_write_next = (s_tuser == sawbc_pkg::MODE_WRITE);
                        cur_set_next   = sawbc_pkg::set_of(in_addr, data_mode_reg);
                        tag_req.rd_en  = 1'b1;
                        tag_req.rd_set = sawbc_pkg::set_of(in_addr, data_mode_reg);
                        state_next     = ST_LOOKUP;
                    end else if (s_tuser == sawbc_pkg::MODE_FILL && pend_valid_reg) begin
                        dat_req.en    = 1'b1;
                        dat_req.we    = 1'b1;
                        dat_req.addr  = {pset, victim_reg, fill_cnt_reg};
                        dat_req.wdata = in_fd;
                        fill_cnt_next = fill_cnt_reg + 3'd1;
                        if (fill_cnt_reg == 3'd7) begin
                            tag_req.rd_en  = 1'b1;
                            tag_req.rd_set = pset;
                            state_next     = ST_FILL;
                        end
                    end
                end
            end
            ST_LOOKUP: begin
                tag_req.wr_en  = 1'b1;
                tag_req.wr_set = cur_set_reg;
                if (hit) begin
                    if (cur_write_reg && data_mode_reg) wr_row[hit_way].dirty = 1'b1;
                    dat_req.en     = 1'b1;
                    dat_req.we     = cur_write_reg;
                    dat_req.addr   = {cur_set_reg, hit_way, cur_addr_reg[4:2]};
                    dat_req.wdata  = cur_data_reg;
                    resp_hit_next  = 1'b1;
                    resp_read_next = !cur_write_reg;
                    state_next     = ST_RESP;
                end else begin
                    wr_row[vict].valid = 1'b0;
                    wr_row[vict].dirty = 1'b0;
                    wb_tag_next     = aged_row[vict].tag[18:0];
                    victim_next     = vict;
                    fill_cnt_next   = 3'd0;
                    pend_valid_next = 1'b1;
                    pend_write_next = cur_write_reg;
                    pend_addr_next  = cur_addr_reg;
                    pend_data_next  = cur_data_reg;
                    wb_cnt_next     = 3'd0;
                    if (!found_empty && data_mode_reg && aged_row[vict].dirty) begin
                        dat_req.en   = 1'b1;
                        dat_req.addr = {cur_set_reg, vict, 3'd0};
                        state_next   = ST_WB;
                    end else begin
                        state_next   = ST_REQ;
                    end
                end
            end
            ST_WB: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    md_next = {dat_rdata, wb_tag_reg, cur_set_reg, wb_cnt_reg, 2'b00, 32'd0};
                    mu_next = {1'b0, sawbc_pkg::KIND_WB};
                    ml_next = 1'b0;
                    wb_cnt_next = wb_cnt_reg + 3'd1;
                    if (wb_cnt_reg == 3'd7) begin
                        state_next = ST_REQ;
                    end else begin
                        dat_req.en   = 1'b1;
                        dat_req.addr = {cur_set_reg, victim_reg, wb_cnt_reg + 3'd1};
                    end
                end
            end
            ST_REQ: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    md_next    = {32'd0, cur_addr_reg[31:5], 5'd0, 32'd0};
                    mu_next    = {1'b0, sawbc_pkg::KIND_REQ};
                    ml_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FILL: begin
                wr_row = rd_row;
                wr_row[victim_reg].valid = 1'b1;
                wr_row[victim_reg].dirty = pend_write_reg && data_mode_reg;
                wr_row[victim_reg].tag   = sawbc_pkg::tag_of(pend_addr_reg, data_mode_reg);
                wr_row[victim_reg].age   = '0;
                tag_req.wr_en   = 1'b1;
                tag_req.wr_set  = pset;
                dat_req.en      = 1'b1;
                dat_req.we      = pend_write_reg;
                dat_req.addr    = {pset, victim_reg, pend_addr_reg[4:2]};
                dat_req.wdata   = pend_data_reg;
                resp_hit_next   = 1'b0;
                resp_read_next  = !pend_write_reg;
                pend_valid_next = 1'b0;
                pend_write_next = 1'b0;
                fill_cnt_next   = 3'd0;
                state_next      = ST_RESP;
            end
            ST_RESP: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    md_next    = {32'd0, 32'd0, resp_read_reg ? dat_rdata : 32'd0};
                    mu_next    = {resp_hit_reg, sawbc_pkg::KIND_DONE};
                    ml_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            data_mode_reg   <= 1'b1;
            active_ways_reg <= 4'd8;
            pend_valid_reg  <= 1'b0;
            pend_write_reg  <= 1'b0;
            victim_reg      <= 3'd0;
            fill_cnt_reg    <= 3'd0;
            mv_reg          <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            pend_write_reg <= pend_write_next;
            victim_reg     <= victim_next;
            fill_cnt_reg   <= fill_cnt_next;
            mv_reg         <= mv_next;
            if (cfg_wen) begin
                case (cfg_index)
                    sawbc_pkg::REG_DATA_MODE:   data_mode_reg   <= cfg_wdata[0];
                    sawbc_pkg::REG_ACTIVE_WAYS: active_ways_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_addr_reg <= pend_addr_next;
        pend_data_reg <= pend_data_next;
        cur_addr_reg  <= cur_addr_next;
        cur_data_reg  <= cur_data_next;
        cur_write_reg <= cur_write_next;
        cur_set_reg   <= cur_set_next;
        wb_cnt_reg    <= wb_cnt_next;
        wb_tag_reg    <= wb_tag_next;
        resp_hit_reg  <= resp_hit_next;
        resp_read_reg <= resp_read_next;
        md_reg        <= md_next;
        mu_reg        <= mu_next;
        ml_reg        <= ml_next;
    end
endmodule
`default_nettype wire

>>> dv/set_assoc_writeback_cache_core_test.sv
// Self-checking bench for set_assoc_writeback_cache_core: streams reads, writes and
// fill beats, predicts completions, writeback beats and fill requests in a local model.
// Depends on sawbc_pkg and the core RTL.
`timescale 1ns / 100ps
module set_assoc_writeback_cache_core_test;

    localparam logic [1:0] MODE_NONE = 2'd3;   // unused mode, block ignores it
    localparam int NLINES = sawbc_pkg::SETS * sawbc_pkg::WAYS;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic [31:0] fdata;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        hit;
        logic [31:0] rdata;
        logic [31:0] maddr;
        logic [31:0] mdata;
        logic        last;
    } rsp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [95:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [95:0] m_tdata;
    wire  [2:0]  m_tuser;
    wire         m_tlast;
    logic        cfg_wen = 1'b0;
    logic        cfg_index = 1'b0;
    logic [3:0]  cfg_wdata = '0;

    set_assoc_writeback_cache_core DUT (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Cache shadow: tag row state, line words, pending miss, registers
    // ---------------------------------------------------------------
    logic                        sh_valid [NLINES];
    logic                        sh_dirty [NLINES];
    logic [sawbc_pkg::TAG_W-1:0] sh_tag   [NLINES];
    logic [sawbc_pkg::AGE_W-1:0] sh_age   [NLINES];
    logic [31:0]                 sh_word  [NLINES*sawbc_pkg::WPL];

    logic        miss_open = 1'b0;
    logic        miss_write;
    logic [31:0] miss_addr;
    logic [31:0] miss_wdata;
    int          miss_way;
    int          fill_beats;

    logic       dmode = 1'b1;
    logic [3:0] nways = 4'd8;

    req_t feed_q[$];
    rsp_t result_q[$];
    int   pushed_cnt = 0;
    int   accepted_cnt = 0;
    int   result_cnt = 0;
    int   err_cnt = 0;
    int   hit_cnt = 0;
    int   wb_cnt = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;

    function automatic int line_set(logic [31:0] a);
        return dmode ? int'(a[12:5]) : int'(a[10:5]);
    endfunction

    function automatic logic [sawbc_pkg::TAG_W-1:0] line_tag(logic [31:0] a);
        return dmode ? sawbc_pkg::TAG_W'(a >> 13) : sawbc_pkg::TAG_W'(a >> 11);
    endfunction

    function automatic void push_result(logic [1:0] k, logic h, logic [31:0] rd,
                                        logic [31:0] ma, logic [31:0] md, logic l);
        rsp_t r;
        r.kind = k; r.hit = h; r.rdata = rd; r.maddr = ma; r.mdata = md; r.last = l;
        result_q.push_back(r);
    endfunction

    // word access on a resident line; returns read word, zero for writes
    function automatic logic [31:0] touch_word(int ln, logic wr, logic [31:0] a,
                                               logic [31:0] wd);
        int w;
        w = ln * sawbc_pkg::WPL + int'(a[4:2]);
        if (wr) begin
            sh_word[w] = wd;
            if (dmode) sh_dirty[ln] = 1'b1;
            return '0;
        end
        return sh_word[w];
    endfunction

    // Model the effect of one accepted item and queue its results.
    function automatic void cache_predict(req_t it);
        int n, s, ln, hw, vic;
        logic hit, empty;
        logic [sawbc_pkg::TAG_W-1:0] t;
        logic [sawbc_pkg::AGE_W-1:0] big;
        logic [63:0] ea;
        logic [31:0] rd;
        n = (nways == 0) ? 1 : (nways > sawbc_pkg::WAYS) ? sawbc_pkg::WAYS : int'(nways);
        if (it.mode == sawbc_pkg::MODE_READ || it.mode == sawbc_pkg::MODE_WRITE) begin
            if (miss_open) return;
            s = line_set(it.addr);
            t = line_tag(it.addr);
            hit = 1'b0;
            hw = 0;
            for (int i = 0; i < n; i++) begin
                ln = s * sawbc_pkg::WAYS + i;
                if (sh_valid[ln] && sh_tag[ln] == t) begin
                    sh_age[ln] = '0;
                    if (!hit) hw = i;
                    hit = 1'b1;
                end else if (sh_valid[ln] && sh_age[ln] != '1) begin
                    sh_age[ln]++;
                end
            end
            if (hit) begin
                rd = touch_word(s * sawbc_pkg::WAYS + hw, it.mode == sawbc_pkg::MODE_WRITE,
                                it.addr, it.wdata);
                push_result(sawbc_pkg::KIND_DONE, 1'b1, rd, '0, '0, 1'b1);
                hit_cnt++;
                return;
            end
            // victim: first empty way, else first oldest
            vic = 0;
            empty = 1'b0;
            big = sh_age[s * sawbc_pkg::WAYS];
            for (int i = 0; i < n; i++) begin
                ln = s * sawbc_pkg::WAYS + i;
                if (!sh_valid[ln]) begin
                    vic = i;
                    empty = 1'b1;
                    break;
                end
                if (sh_age[ln] > big) begin
                    big = sh_age[ln];
                    vic = i;
                end
            end
            ln = s * sawbc_pkg::WAYS + vic;
            if (!empty && dmode && sh_valid[ln] && sh_dirty[ln]) begin
                ea = (64'(sh_tag[ln]) << 13) | (64'(s) << 5);
                for (int i = 0; i < sawbc_pkg::WPL; i++)
                    push_result(sawbc_pkg::KIND_WB, 1'b0, '0, ea[31:0] + 32'(4 * i),
                                sh_word[ln * sawbc_pkg::WPL + i], 1'b0);
                wb_cnt++;
            end
            sh_valid[ln] = 1'b0;
            sh_dirty[ln] = 1'b0;
            push_result(sawbc_pkg::KIND_REQ, 1'b0, '0, {it.addr[31:5], 5'b0}, '0, 1'b1);
            miss_open = 1'b1;
            miss_write = (it.mode == sawbc_pkg::MODE_WRITE);
            miss_addr = it.addr;
            miss_wdata = it.wdata;
            miss_way = vic;
            fill_beats = 0;
        end else if (it.mode == sawbc_pkg::MODE_FILL) begin
            if (!miss_open) return;
            s = line_set(miss_addr);
            ln = s * sawbc_pkg::WAYS + miss_way;
            sh_word[ln * sawbc_pkg::WPL + fill_beats] = it.fdata;
            fill_beats++;
            if (fill_beats < sawbc_pkg::WPL) return;
            sh_valid[ln] = 1'b1;
            sh_dirty[ln] = 1'b0;
            sh_tag[ln] = line_tag(miss_addr);
            sh_age[ln] = '0;
            rd = touch_word(ln, miss_write, miss_addr, miss_wdata);
            push_result(sawbc_pkg::KIND_DONE, 1'b0, rd, '0, '0, 1'b1);
            miss_open = 1'b0;
            fill_beats = 0;
        end
    endfunction

    // ---------------------------------------------------------------
    // Driver: presents queued items, predicts at each handshake
    // ---------------------------------------------------------------
    req_t cur_item;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                cache_predict(cur_item);
                accepted_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (feed_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    cur_item = feed_q.pop_front();
                    s_tdata  <= {cur_item.fdata, cur_item.wdata, cur_item.addr};
                    s_tuser  <= cur_item.mode;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random back-pressure, in-order field compare
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        rsp_t e;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                result_cnt++;
                if (result_q.size() == 0) begin
                    $error("unexpected result kind=%0d addr=%h", m_tuser[1:0], m_tdata[63:32]);
                    err_cnt++;
                end else begin
                    e = result_q.pop_front();
                    if (m_tuser[1:0] !== e.kind) begin
                        $error("kind exp %0d got %0d", e.kind, m_tuser[1:0]); err_cnt++;
                    end
                    if (m_tuser[2] !== e.hit) begin
                        $error("hit exp %0d got %0d", e.hit, m_tuser[2]); err_cnt++;
                    end
                    if (m_tdata[31:0] !== e.rdata) begin
                        $error("read_data exp %h got %h", e.rdata, m_tdata[31:0]); err_cnt++;
                    end
                    if (m_tdata[63:32] !== e.maddr) begin
                        $error("mem_addr exp %h got %h", e.maddr, m_tdata[63:32]); err_cnt++;
                    end
                    if (m_tdata[95:64] !== e.mdata) begin
                        $error("mem_data exp %h got %h", e.mdata, m_tdata[95:64]); err_cnt++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last exp %0d got %0d", e.last, m_tlast); err_cnt++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    logic [18:0] tag_pool[12];

    task automatic push_item(logic [1:0] m, logic [31:0] a);
        req_t it;
        it.mode = m; it.addr = a; it.wdata = $urandom; it.fdata = $urandom;
        feed_q.push_back(it);
        pushed_cnt++;
    endtask

    task automatic wait_accepted();
        while (accepted_cnt != pushed_cnt) @(posedge aclk);
    endtask

    // one access; on a miss, feed the eight fill beats with some noise in between
    task automatic run_access(logic [1:0] m, logic [31:0] a, bit noisy);
        int beats;
        push_item(m, a);
        wait_accepted();
        if (!miss_open) return;
        beats = 0;
        while (beats < sawbc_pkg::WPL) begin
            if (noisy && $urandom_range(99) < 6)
                push_item(logic'($urandom_range(1)) ? sawbc_pkg::MODE_READ
                                                   : sawbc_pkg::MODE_WRITE, $urandom);
            else if (noisy && $urandom_range(99) < 3)
                push_item(MODE_NONE, $urandom);
            else begin
                push_item(sawbc_pkg::MODE_FILL, $urandom);
                beats++;
            end
        end
        wait_accepted();
    endtask

    // block is idle only once every result is out and the sequencer drained
    task automatic write_reg(logic idx, logic [3:0] val);
        while (result_q.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        if (idx == sawbc_pkg::REG_DATA_MODE) dmode = val[0];
        else nways = val;
    endtask

    function automatic logic [31:0] pick_addr();
        logic [31:0] a;
        int r;
        r = $urandom_range(99);
        if (r < 8) return $urandom;
        a = $urandom;
        a[31:13] = tag_pool[$urandom_range(11)];
        a[12:5] = (r < 60) ? 8'd3 : (r < 85) ? 8'(64 + $urandom_range(1)) : 8'hFF;
        return a;
    endfunction

    initial begin
        int dm_set[6] = '{1, 0, 1, 1, 0, 1};
        int aw_set[6] = '{8, 2, 15, 0, 8, 3};
        int idle_set[4] = '{0, 54, 0, 6};
        int stall_set[4] = '{0, 0, 54, 6};
        int r;

        for (int i = 0; i < NLINES; i++) begin
            sh_valid[i] = 1'b0; sh_dirty[i] = 1'b0; sh_tag[i] = '0; sh_age[i] = '0;
        end
        for (int i = 0; i < NLINES * sawbc_pkg::WPL; i++) sh_word[i] = '0;
        foreach (tag_pool[i]) tag_pool[i] = 19'($urandom);
        tag_pool[0] = '0;
        tag_pool[1] = '1;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: one way per set so dirty lines get evicted at once
        write_reg(sawbc_pkg::REG_ACTIVE_WAYS, 4'd1);
        push_item(sawbc_pkg::MODE_FILL, 32'h0);                  // fill with no miss open
        push_item(MODE_NONE, 32'hFFFF_FFFF);                     // unused mode
        run_access(sawbc_pkg::MODE_WRITE, 32'h0000_0000, 1'b0);  // write miss, allocate
        run_access(sawbc_pkg::MODE_WRITE, 32'h0000_001C, 1'b0);  // write hit, last word
        run_access(sawbc_pkg::MODE_READ,  32'h0000_0000, 1'b0);  // read hit
        push_item(sawbc_pkg::MODE_READ, 32'hFFFF_FFE0);          // miss ...
        push_item(sawbc_pkg::MODE_WRITE, 32'h0000_0000);         // ... access while pending
        push_item(MODE_NONE, 32'h0);
        wait_accepted();
        repeat (sawbc_pkg::WPL) push_item(sawbc_pkg::MODE_FILL, 32'h0);
        wait_accepted();
        run_access(sawbc_pkg::MODE_WRITE, 32'hFFFF_FFFC, 1'b0);  // dirty top line
        run_access(sawbc_pkg::MODE_READ,  32'h7FFF_FFE4, 1'b0);  // evicts dirty line
        run_access(sawbc_pkg::MODE_READ,  32'h0000_2000, 1'b0);  // set 0, dirty victim
        write_reg(sawbc_pkg::REG_DATA_MODE, 4'd0);
        run_access(sawbc_pkg::MODE_WRITE, 32'h8000_0404, 1'b0);  // instruction mode: no dirty
        run_access(sawbc_pkg::MODE_READ,  32'h0000_0404, 1'b0);  // evicts without writeback
        run_access(sawbc_pkg::MODE_READ,  32'h8000_0404, 1'b0);

        // random phases over register settings and idling patterns
        for (int p = 0; p < 6; p++) begin
            write_reg(sawbc_pkg::REG_DATA_MODE, 4'(dm_set[p]));
            write_reg(sawbc_pkg::REG_ACTIVE_WAYS, 4'(aw_set[p]));
            idle_pct = idle_set[p % 4];
            stall_pct = stall_set[p % 4];
            for (int k = 0; k < 8; k++) begin
                r = $urandom_range(99);
                if (r < 46) run_access(sawbc_pkg::MODE_READ, pick_addr(), 1'b1);
                else if (r < 92) run_access(sawbc_pkg::MODE_WRITE, pick_addr(), 1'b1);
                else if (r < 96) push_item(sawbc_pkg::MODE_FILL, $urandom);
                else push_item(MODE_NONE, $urandom);
            end
            wait_accepted();
        end

        wait_accepted();
        while (result_q.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        $display("Covered %0d items, %0d results: %0d hits, %0d dirty writebacks.",
                 accepted_cnt, result_cnt, hit_cnt, wb_cnt);
        $display("Both register settings, 1 to 8 ways incl. clamped values, four idle mixes.");
        if (err_cnt == 0 && result_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout: %0d results still expected", result_q.size());
        $display("Mismatches found");
        $finish;
    end
endmodule
